@@ rtl/eih_pkg.sv @@
`default_nettype none

package eih_pkg;

   localparam int TICK_W  = 10;
   localparam int PIN_W   = 5;
   localparam int WORD_W  = 32;
   localparam int TIME_W  = 64;
   localparam int COUNT_W = 32;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 3;

   localparam logic [TICK_W-1:0]  TICK_RESET = TICK_W'(1);
   localparam logic [PIN_W-1:0]   PIN_RESET  = PIN_W'(4);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

   // register index, taken from address bit 2
   typedef enum logic {
      REG_TICK_STEP  = 1'b0,
      REG_PIN_SELECT = 1'b1
   } reg_index_type;

   // result queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // one lookup issued towards the histogram
   typedef struct packed {
      logic inc;
   } lookup_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/eih_hist.sv @@
`default_nettype none

module eih_hist #(
   parameter int HIST_BINS = 32768
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire eih_pkg::lookup_ctrl_type      lk_ctrl,
   input  wire logic [$clog2(HIST_BINS)-1:0]  lk_addr,
   output logic                               busy,
   output logic [eih_pkg::COUNT_W-1:0]        count
);
   import eih_pkg::*;

   localparam int AW = $clog2(HIST_BINS);
   localparam logic [AW-1:0] LAST_BIN = AW'(HIST_BINS - 1);

   logic [COUNT_W-1:0] mem [HIST_BINS];

   logic               clr_ff, clr_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic               s2_inc_ff;
   logic [AW-1:0]      s2_addr_ff;
   logic [COUNT_W-1:0] rdata_ff;
   logic               fwd_v_ff, fwd_v_in;
   logic [AW-1:0]      fwd_addr_ff;
   logic [COUNT_W-1:0] fwd_data_ff;

   logic [COUNT_W-1:0] cur;
   logic [COUNT_W-1:0] nxt;
   logic               we;
   logic [AW-1:0]      waddr;
   logic [COUNT_W-1:0] wdata;

   // clearing sweep after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_BIN) begin
            clr_in = 1'b0;
         end
      end
   end

   // last write forwarded over the read-during-write hazard
   always_comb begin
      cur   = (fwd_v_ff && fwd_addr_ff == s2_addr_ff) ? fwd_data_ff : rdata_ff;
      nxt   = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);
      we    = clr_ff || s2_inc_ff;
      waddr = clr_ff ? clr_addr_ff : s2_addr_ff;
      wdata = clr_ff ? '0 : nxt;
      fwd_v_in = fwd_v_ff || (s2_inc_ff && !clr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         s2_inc_ff   <= 1'b0;
         fwd_v_ff    <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         s2_inc_ff   <= lk_ctrl.inc;
         fwd_v_ff    <= fwd_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_addr_ff <= lk_addr;
      if (s2_inc_ff) begin
         fwd_addr_ff <= s2_addr_ff;
         fwd_data_ff <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[lk_addr];
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   assign busy  = clr_ff;
   assign count = nxt;

`ifndef SYNTH
   a_no_lookup_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !lk_ctrl.inc)
      else $error("lookup issued during clearing sweep");
   a_count_never_wraps: assert property (@(posedge clock) disable iff (reset)
      (s2_inc_ff && !clr_ff) |-> (nxt != '0))
      else $error("bin count wrapped to zero");
   a_sweep_ends_once: assert property (@(posedge clock) disable iff (reset)
      !clr_ff |=> !clr_ff)
      else $error("clearing sweep restarted");
`endif

endmodule

`default_nettype wire

@@ rtl/edge_interval_histogram.sv @@
`default_nettype none
// throughput: one request per cycle while req_ready is high, set by the single
//   histogram read-modify-write (read issued in one stage, written back in the
//   next, with one forwarding register)
// reset: control and configuration registers return to their reset values and the
//   histogram is swept to zero, one bin per cycle, with req_ready low; csr writes are taken
module edge_interval_histogram #(
   parameter int HIST_BINS = 32768
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [eih_pkg::WORD_W-1:0]     req_sample_word,
   input  wire logic                           req_has_timestamp,
   input  wire logic [eih_pkg::TIME_W-1:0]     req_timestamp,
   // result channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_edge_seen,
   output logic [eih_pkg::TIME_W-1:0]          rsp_pulse_width,
   output logic [eih_pkg::COUNT_W-1:0]         rsp_bin_count,
   output logic                                rsp_width_overflow,
   // register port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [eih_pkg::ADDR_W-1:0]     paddr,
   input  wire logic [eih_pkg::CSR_W-1:0]      pwdata,
   output logic [eih_pkg::CSR_W-1:0]           prdata,
   output logic                                pready
);
   import eih_pkg::*;

   localparam int AW = $clog2(HIST_BINS);
   localparam logic [TIME_W-1:0] BINS_T = TIME_W'(HIST_BINS);

   // configuration registers
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [PIN_W-1:0]  pin_ff, pin_in;
   logic              csr_wr;
   reg_index_type     csr_idx;

   // front-end state
   logic [TIME_W-1:0] sample_time_ff, sample_time_in;
   logic [TIME_W-1:0] last_edge_ff, last_edge_in;
   logic              last_level_ff, last_level_in;
   logic              primed_ff, primed_in;

   // accept-stage logic
   logic              accept;
   logic [TIME_W-1:0] st_use;
   logic [TIME_W-1:0] diff;
   logic              level;
   logic              edge_now;
   logic              ovf_now;

   // stage 1: histogram read issued
   logic              s1_v_ff;
   logic              s1_edge_ff;
   logic [TIME_W-1:0] s1_width_ff;
   logic              s1_ovf_ff;
   logic              s1_inc_ff;

   // stage 2: read data back, bin written, result queued
   logic              s2_v_ff;
   logic              s2_edge_ff;
   logic [TIME_W-1:0] s2_width_ff;
   logic              s2_ovf_ff;
   logic              s2_inc_ff;

   lookup_ctrl_type      lk_ctrl;
   logic                 hist_busy;
   logic [COUNT_W-1:0]   hist_count;

   // result queue, parts the pipeline from the consumer
   logic              q_edge [QDEPTH];
   logic [TIME_W-1:0] q_width [QDEPTH];
   logic [COUNT_W-1:0] q_count [QDEPTH];
   logic              q_ovf [QDEPTH];
   logic [QPTR_W-1:0] q_wr_ff, q_wr_in;
   logic [QPTR_W-1:0] q_rd_ff, q_rd_in;
   logic [QCNT_W-1:0] q_cnt_ff, q_cnt_in;
   logic [QCNT_W-1:0] in_flight;
   logic              push;
   logic              pop;

   // ---------------------------------------------------------------- csr
   // register chosen by address bit 2 alone
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_index_type'(paddr[2]);
   assign pready  = 1'b1;

   always_comb begin
      tick_in = tick_ff;
      pin_in  = pin_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_TICK_STEP:  tick_in = pwdata[TICK_W-1:0];
            REG_PIN_SELECT: pin_in  = pwdata[PIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_TICK_STEP:  prdata = CSR_W'(tick_ff);
         REG_PIN_SELECT: prdata = CSR_W'(pin_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- front end
   // a fresh timestamp replaces the running time before use; the time then
   // advances by the tick step. the first sample only primes the edge time
   assign accept = req_valid && req_ready;

   always_comb begin
      st_use   = req_has_timestamp ? req_timestamp : sample_time_ff;
      diff     = st_use - last_edge_ff;
      level    = req_sample_word[pin_ff];
      edge_now = primed_ff && (level != last_level_ff);
      ovf_now  = edge_now && (diff >= BINS_T);

      sample_time_in = sample_time_ff;
      last_edge_in   = last_edge_ff;
      last_level_in  = last_level_ff;
      primed_in      = primed_ff;
      if (accept) begin
         sample_time_in = st_use + TIME_W'(tick_ff);
         last_level_in  = level;
         primed_in      = 1'b1;
         if (!primed_ff || edge_now) begin
            last_edge_in = st_use;
         end
      end
   end

   // ------------------------------------------------------- pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= TICK_RESET;
         pin_ff         <= PIN_RESET;
         sample_time_ff <= '0;
         last_edge_ff   <= '0;
         last_level_ff  <= 1'b0;
         primed_ff      <= 1'b0;
         s1_v_ff        <= 1'b0;
         s1_inc_ff      <= 1'b0;
         s2_v_ff        <= 1'b0;
         s2_inc_ff      <= 1'b0;
         q_wr_ff        <= '0;
         q_rd_ff        <= '0;
         q_cnt_ff       <= '0;
      end else begin
         tick_ff        <= tick_in;
         pin_ff         <= pin_in;
         sample_time_ff <= sample_time_in;
         last_edge_ff   <= last_edge_in;
         last_level_ff  <= last_level_in;
         primed_ff      <= primed_in;
         s1_v_ff        <= accept;
         s1_inc_ff      <= accept && edge_now && !ovf_now;
         s2_v_ff        <= s1_v_ff;
         s2_inc_ff      <= s1_v_ff && s1_inc_ff;
         q_wr_ff        <= q_wr_in;
         q_rd_ff        <= q_rd_in;
         q_cnt_ff       <= q_cnt_in;
      end
   end

   // payload, no reset; a width is only reported with an edge
   always_ff @(posedge clock) begin
      s1_edge_ff  <= edge_now;
      s1_width_ff <= edge_now ? diff : '0;
      s1_ovf_ff   <= ovf_now;
      s2_edge_ff  <= s1_edge_ff;
      s2_width_ff <= s1_width_ff;
      s2_ovf_ff   <= s1_ovf_ff;
   end

   // --------------------------------------------------------- histogram
   assign lk_ctrl.inc = s1_v_ff && s1_inc_ff;

   eih_hist #(
      .HIST_BINS (HIST_BINS)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .lk_ctrl (lk_ctrl),
      .lk_addr (s1_width_ff[AW-1:0]),
      .busy    (hist_busy),
      .count   (hist_count)
   );

   // ------------------------------------------------------ result queue
   // room is kept for every request still in the pipeline
   assign push      = s2_v_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign in_flight = q_cnt_ff + QCNT_W'(s1_v_ff) + QCNT_W'(s2_v_ff);
   assign req_ready = !hist_busy && (in_flight < QCNT_W'(QDEPTH));

   always_comb begin
      q_wr_in  = push ? q_wr_ff + QPTR_W'(1) : q_wr_ff;
      q_rd_in  = pop ? q_rd_ff + QPTR_W'(1) : q_rd_ff;
      q_cnt_in = q_cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_edge[q_wr_ff]  <= s2_edge_ff;
         q_width[q_wr_ff] <= s2_width_ff;
         q_count[q_wr_ff] <= s2_inc_ff ? hist_count : '0;
         q_ovf[q_wr_ff]   <= s2_ovf_ff;
      end
   end

   assign rsp_valid          = (q_cnt_ff != '0);
   assign rsp_edge_seen      = q_edge[q_rd_ff];
   assign rsp_pulse_width    = q_width[q_rd_ff];
   assign rsp_bin_count      = q_count[q_rd_ff];
   assign rsp_width_overflow = q_ovf[q_rd_ff];

`ifndef SYNTH
   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      hist_busy |-> !req_ready)
      else $error("request taken during histogram clearing");
   a_queue_never_overfills: assert property (@(posedge clock) disable iff (reset)
      in_flight <= QCNT_W'(QDEPTH))
      else $error("result queue overcommitted");
   a_overflow_not_counted: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && s2_ovf_ff) |-> !s2_inc_ff)
      else $error("overflowed width counted in histogram");
   a_primed_holds: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("primed flag dropped without reset");
`endif

endmodule

`default_nettype wire

@@ dv/tb_edge_interval_histogram.sv @@
module tb_edge_interval_histogram;

   import eih_pkg::*;

   localparam int HIST_BINS   = 32768;
   // no activity at all for this long means a hang; covers the histogram sweep after reset
   localparam int STALL_LIMIT = 4 * HIST_BINS + 20000;

   // one expected interval report
   typedef struct packed {
      logic                edge_seen;
      logic [TIME_W-1:0]   pulse_width;
      logic [COUNT_W-1:0]  bin_count;
      logic                width_overflow;
   } interval_report_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [WORD_W-1:0]   req_sample_word;
   logic                req_has_timestamp;
   logic [TIME_W-1:0]   req_timestamp;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_edge_seen;
   logic [TIME_W-1:0]   rsp_pulse_width;
   logic [COUNT_W-1:0]  rsp_bin_count;
   logic                rsp_width_overflow;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [CSR_W-1:0]    pwdata;
   logic [CSR_W-1:0]    prdata;
   logic                pready;

   // shadow of the block: configuration and measurement state
   logic [TICK_W-1:0]   shadow_tick;
   logic [PIN_W-1:0]    shadow_pin;
   logic [TIME_W-1:0]   shadow_sample_time;
   logic [TIME_W-1:0]   shadow_last_edge;
   logic                shadow_level;
   logic                shadow_primed;
   logic [COUNT_W-1:0]  width_bins [int];

   interval_report_type expected_intervals [$];
   int                  mismatch_count;
   int                  sender_idle_pct;
   int                  receiver_idle_pct;
   logic                receiver_hold;
   int                  quiet_cycles;

   edge_interval_histogram #(
      .HIST_BINS (HIST_BINS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_word    (req_sample_word),
      .req_has_timestamp  (req_has_timestamp),
      .req_timestamp      (req_timestamp),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_edge_seen      (rsp_edge_seen),
      .rsp_pulse_width    (rsp_pulse_width),
      .rsp_bin_count      (rsp_bin_count),
      .rsp_width_overflow (rsp_width_overflow),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // 10 unit period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // one line per mismatch, and keep count
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // works out the report for one accepted request and advances the shadow state
   function automatic interval_report_type measure_interval(input logic [WORD_W-1:0] word,
                                                            input logic has_ts,
                                                            input logic [TIME_W-1:0] ts);
      interval_report_type rep;
      logic             level;
      logic [TIME_W-1:0] width;
      int               bin;
      rep = '0;
      if (has_ts) begin
         shadow_sample_time = ts;
      end
      level = word[shadow_pin];
      if (!shadow_primed) begin
         // first sample only sets the reference point
         shadow_primed    = 1'b1;
         shadow_last_edge = shadow_sample_time;
      end else if (level != shadow_level) begin
         width             = shadow_sample_time - shadow_last_edge;
         rep.edge_seen     = 1'b1;
         rep.pulse_width   = width;
         shadow_last_edge  = shadow_sample_time;
         if (width < TIME_W'(HIST_BINS)) begin
            bin = int'(width);
            if (!width_bins.exists(bin)) begin
               width_bins[bin] = '0;
            end
            // saturating bin count
            if (width_bins[bin] != COUNT_MAX) begin
               width_bins[bin] = width_bins[bin] + COUNT_W'(1);
            end
            rep.bin_count = width_bins[bin];
         end else begin
            rep.width_overflow = 1'b1;
         end
      end
      shadow_level       = level;
      shadow_sample_time = shadow_sample_time + TIME_W'(shadow_tick);
      return rep;
   endfunction

   // random sample word with the watched pin forced to a chosen level
   function automatic logic [WORD_W-1:0] word_at_level(input logic lvl);
      logic [WORD_W-1:0] w;
      w = $urandom;
      w[shadow_pin] = lvl;
      return w;
   endfunction

   // offers one request; called and returns just after a falling edge, valid left high
   task automatic send_sample(input logic [WORD_W-1:0] word, input logic has_ts,
                              input logic [TIME_W-1:0] ts);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_word   <= word;
      req_has_timestamp <= has_ts;
      req_timestamp     <= ts;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected_intervals.push_back(measure_interval(word, has_ts, ts));
      @(negedge clock);
   endtask

   // lowers valid and waits for every outstanding report
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (expected_intervals.size() != 0);
   endtask

   task automatic read_register(input reg_index_type idx, output logic [CSR_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'({idx, 2'b00});
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      data = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_register(input reg_index_type idx, input logic [CSR_W-1:0] want);
      logic [CSR_W-1:0] got;
      read_register(idx, got);
      if (got !== want) begin
         report_mismatch(idx.name(), 64'(got), 64'(want));
      end
   endtask

   // write then read back
   task automatic write_register(input reg_index_type idx, input logic [CSR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      case (idx)
         REG_TICK_STEP: begin
            shadow_tick = value[TICK_W-1:0];
         end
         REG_PIN_SELECT: begin
            shadow_pin = value[PIN_W-1:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      check_register(idx, value);
   endtask

   // registers change only with the block idle
   task automatic configure(input int tick, input int pin);
      wait_results_drained();
      write_register(REG_TICK_STEP, CSR_W'(tick));
      write_register(REG_PIN_SELECT, CSR_W'(pin));
   endtask

   // mostly short pulses so widths land in the histogram, with a few timer reloads
   task automatic send_random_sample();
      logic [WORD_W-1:0] word;
      logic              has_ts;
      logic [TIME_W-1:0] ts;
      int                kind;
      word   = word_at_level(($urandom_range(0, 99) < 40) ? !shadow_level : shadow_level);
      ts     = {$urandom, $urandom};
      has_ts = 1'b0;
      if ($urandom_range(0, 99) < 8) begin
         has_ts = 1'b1;
         kind   = $urandom_range(0, 9);
         if (kind < 6) begin
            ts = shadow_sample_time + TIME_W'($urandom_range(0, 3000));
         end else if (kind < 8) begin
            // timer stepping backwards wraps the width
            ts = shadow_sample_time - TIME_W'($urandom_range(1, 500));
         end
      end
      send_sample(word, has_ts, ts);
   endtask

   // --- tests ---

   // priming sample, rising and falling edges and steady levels under reset settings
   task automatic test_priming_and_edges();
      check_register(REG_TICK_STEP, CSR_W'(TICK_RESET));
      check_register(REG_PIN_SELECT, CSR_W'(PIN_RESET));
      configure(1, 4);
      send_sample(32'h0000_0000, 1'b0, '0);
      send_sample(32'hFFFF_FFFF, 1'b0, '1);
      send_sample(32'hFFFF_FFFF, 1'b0, '0);
      send_sample(32'hFFFF_FFEF, 1'b0, '0);
      send_sample(32'h0000_0010, 1'b0, '0);
      send_sample(32'h0000_0010, 1'b0, '0);
   endtask

   // zero step, step above the nominal range, lowest and highest pin
   task automatic test_register_extremes();
      configure(0, 0);
      send_sample(32'h0000_0000, 1'b0, '0);
      send_sample(32'h0000_0001, 1'b0, '0);
      send_sample(32'hFFFF_FFFE, 1'b0, '0);
      configure(1023, 31);
      send_sample(32'h8000_0000, 1'b0, '0);
      send_sample(32'h0000_0000, 1'b0, '0);
      send_sample(32'h7FFF_FFFF, 1'b0, '0);
   endtask

   // timer reloads: last bin, first overflowing width, wrap of time and width
   task automatic test_timestamp_reloads();
      configure(1000, 4);
      send_sample(word_at_level(!shadow_level), 1'b1, '0);
      send_sample(word_at_level(!shadow_level), 1'b1,
                  shadow_last_edge + TIME_W'(HIST_BINS - 1));
      send_sample(word_at_level(!shadow_level), 1'b1,
                  shadow_last_edge + TIME_W'(HIST_BINS));
      send_sample(word_at_level(shadow_level), 1'b1, '1);
      send_sample(word_at_level(!shadow_level), 1'b0, {$urandom, $urandom});
      send_sample(word_at_level(!shadow_level), 1'b1, shadow_last_edge);
      send_sample(word_at_level(shadow_level), 1'b0, '1);
   endtask

   // slow receiver, with one pause until everything is back
   task automatic test_random_slow_receiver();
      configure($urandom_range(1, 40), $urandom_range(0, 31));
      sender_idle_pct   = 25;
      receiver_idle_pct = 74;
      for (int n = 0; n < 270; n++) begin
         if (n == 130) begin
            wait_results_drained();
         end
         send_random_sample();
      end
   endtask

   // slow sender at the largest nominal step
   task automatic test_random_slow_sender();
      configure(1000, 31);
      sender_idle_pct   = 74;
      receiver_idle_pct = 25;
      for (int n = 0; n < 260; n++) begin
         send_random_sample();
      end
   endtask

   // full rate, with one long receiver stall so the block backs up
   task automatic test_random_full_rate();
      configure(1, 0);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      for (int n = 0; n < 260; n++) begin
         if (n == 100) begin
            fork
               begin
                  receiver_hold = 1'b1;
                  repeat (300) @(negedge clock);
                  receiver_hold = 1'b0;
               end
            join_none
         end
         send_random_sample();
      end
   endtask

   // receiver: random back-pressure, or a held-off stretch
   always @(negedge clock) begin
      rsp_ready <= !receiver_hold && ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // compare each report with the oldest expectation
   always @(posedge clock) begin
      interval_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_intervals.size() == 0) begin
            report_mismatch("unexpected report, pulse_width", rsp_pulse_width, '0);
         end else begin
            want = expected_intervals.pop_front();
            if (rsp_edge_seen !== want.edge_seen) begin
               report_mismatch("edge_seen", 64'(rsp_edge_seen), 64'(want.edge_seen));
            end
            if (rsp_pulse_width !== want.pulse_width) begin
               report_mismatch("pulse_width", rsp_pulse_width, want.pulse_width);
            end
            if (rsp_bin_count !== want.bin_count) begin
               report_mismatch("bin_count", 64'(rsp_bin_count), 64'(want.bin_count));
            end
            if (rsp_width_overflow !== want.width_overflow) begin
               report_mismatch("width_overflow", 64'(rsp_width_overflow),
                               64'(want.width_overflow));
            end
         end
      end
   end

   // hang detection: counts cycles with no request, report or register access
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_sample_word    = '0;
      req_has_timestamp  = 1'b0;
      req_timestamp      = '0;
      rsp_ready          = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      quiet_cycles       = 0;
      mismatch_count     = 0;
      sender_idle_pct    = 0;
      receiver_idle_pct  = 0;
      receiver_hold      = 1'b0;
      // shadow starts from the reset state
      shadow_tick        = TICK_RESET;
      shadow_pin         = PIN_RESET;
      shadow_sample_time = '0;
      shadow_last_edge   = '0;
      shadow_level       = 1'b0;
      shadow_primed      = 1'b0;
      // reset held, then released just after a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_priming_and_edges();
      test_register_extremes();
      test_timestamp_reloads();
      test_random_slow_receiver();
      test_random_slow_sender();
      test_random_full_rate();

      // let any stray report show up
      wait_results_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/eih_pkg.sv
rtl/eih_hist.sv
rtl/edge_interval_histogram.sv
dv/tb_edge_interval_histogram.sv
